@@ rtl/core/fta_pkg.sv @@
// Package for the fixed timestep accumulator: constants, register indexes and payload types.
`default_nettype none
package fta_pkg;
  localparam int unsigned SCALE_FRAC_BITS = 8;
  localparam logic [32:0] FPS_WINDOW_NS = 33'd1000000000;
  // 10^9 * 256 as a frame-count multiplier for the rate calculation.
  localparam logic [37:0] NS_PER_SEC_Q8 = 38'd256000000000;
  // 10^9 on its own; the factor of 256 is applied as a shift.
  localparam logic [29:0] NS_PER_SEC = 30'd1000000000;
  localparam logic [15:0] UNIT_SCALE = 16'd256;

  localparam logic [1:0] CMD_FRAME  = 2'd0;
  localparam logic [1:0] CMD_PAUSE  = 2'd1;
  localparam logic [1:0] CMD_RESUME = 2'd2;
  localparam logic [1:0] CMD_RESET  = 2'd3;

  localparam logic [1:0] REG_STEP      = 2'd0;
  localparam logic [1:0] REG_MAX_FRAME = 2'd1;
  localparam logic [1:0] REG_MAX_STEPS = 2'd2;
  localparam logic [1:0] REG_SCALE     = 2'd3;

  typedef struct packed {
    logic [1:0]  command;
    logic [63:0] timestamp_ns;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  physics_steps;
    logic        lagging;
    logic [15:0] interp_alpha;
    logic [39:0] scaled_frame_ns;
    logic [31:0] raw_frame_ns;
    logic [31:0] capped_frame_ns;
    logic [15:0] current_scale;
    logic [23:0] average_fps;
    logic        is_paused;
    logic        first_frame;
  } out_item_t;
endpackage
`default_nettype wire

@@ rtl/core/fta_if.sv @@
// Valid/ready channel interfaces for the input and result transactions.
`default_nettype none
interface fta_in_if import fta_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface fta_out_if import fta_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/core/fixed_timestep_accumulator.sv @@
// Top level of the fixed timestep accumulator with its shared divider sequencer.
//
// Each transaction takes one command. Pause, resume and reset present their result in the
// cycle after the command is accepted, as does the first begin_frame after reset or a reset
// command. Any other begin_frame passes through the scale multiply state, then one restoring
// divider, one quotient bit a cycle, that serves the whole-step division and the alpha
// division, and a closing state. When a one-second window closes, the same divider also runs
// a third division for the frame rate before the closing state. The input is not ready while
// a frame is worked on or while a result waits, so the next command is accepted in the cycle
// after the result transaction at the earliest.
`default_nettype none
module fixed_timestep_accumulator import fta_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  fta_in_if.sink           in_ch,
  fta_out_if.source        out_ch
);
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MUL   = 3'd1;
  localparam logic [2:0] ST_DIVW  = 3'd2;
  localparam logic [2:0] ST_DIVA  = 3'd3;
  localparam logic [2:0] ST_DIVF  = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  // Configuration registers.
  logic [31:0] step_r, max_frame_r;
  logic [7:0]  max_steps_r;
  logic [15:0] scale_r;
  // Block state.
  logic [63:0] last_stamp_r;
  logic        await_r, paused_r, forced_r;
  logic [31:0] leftover_r, win_frames_r;
  logic [32:0] win_ns_r;
  logic [23:0] fps_r;
  // Sequencer and work registers.
  logic [2:0]  state_r;
  logic [6:0]  cnt_r;
  logic [63:0] quo_r;
  logic [64:0] rem_r;
  logic [63:0] dvsr_r;
  logic [31:0] raw_r, capped_r;
  logic [15:0] cur_scale_r;
  logic [39:0] scaled_r;
  logic        out_valid_r;
  out_item_t   out_r;

  logic [15:0] eff_scale;
  logic [31:0] step_eff;
  logic [7:0]  lim;
  logic [63:0] diff;
  logic [31:0] raw_c;
  logic [47:0] prod;
  logic [64:0] trial;
  logic [63:0] quo_fin;
  logic [63:0] rem_fin;
  logic [55:0] fps_prod;
  logic [32:0] win_sum;
  logic [31:0] frames_inc;
  logic        in_fire;

  // Effective scale and the zero-means-one rules.
  always_comb begin
    if (paused_r) eff_scale = '0;
    else if (forced_r) eff_scale = UNIT_SCALE;
    else eff_scale = scale_r;
  end
  assign step_eff = (step_r == '0) ? 32'd1 : step_r;
  assign lim      = (max_steps_r == '0) ? 8'd1 : max_steps_r;

  // Interval from the last stamp, clamped both ways.
  assign diff  = in_ch.data.timestamp_ns - last_stamp_r;
  assign raw_c = (in_ch.data.timestamp_ns <= last_stamp_r) ? '0 :
                 (diff[63:32] != '0) ? 32'hFFFF_FFFF : diff[31:0];
  assign prod  = capped_r * cur_scale_r;
  // One restoring division step shared by every division.
  assign trial = {rem_r[63:0], quo_r[63]} - {1'b0, dvsr_r};
  // Quotient and remainder as they stand after the last step of a division.
  assign quo_fin = {quo_r[62:0], !trial[64]};
  assign rem_fin = trial[64] ? {rem_r[62:0], quo_r[63]} : trial[63:0];
  // Frame count times 10^9; at most 2^26 frames reach this path.
  assign fps_prod   = frames_inc[26:0] * NS_PER_SEC;
  assign win_sum    = win_ns_r + {1'b0, raw_r};
  assign frames_inc = (win_frames_r == 32'hFFFF_FFFF) ? win_frames_r : win_frames_r + 32'd1;

  assign in_fire      = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = (state_r == ST_IDLE) && !out_valid_r;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= 32'd16666667;
      max_frame_r <= 32'd250000000;
      max_steps_r <= 8'd5;
      scale_r <= UNIT_SCALE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_STEP:      step_r <= cfg_data;
        REG_MAX_FRAME: max_frame_r <= cfg_data;
        REG_MAX_STEPS: max_steps_r <= cfg_data[7:0];
        REG_SCALE:     scale_r <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Command sequencer and shared divider.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      out_valid_r <= 1'b0;
      last_stamp_r <= '0;
      await_r <= 1'b1;
      paused_r <= 1'b0;
      forced_r <= 1'b0;
      leftover_r <= '0;
      win_frames_r <= '0;
      win_ns_r <= '0;
      fps_r <= '0;
      cnt_r <= '0;
    end else begin
      if (out_valid_r && out_ch.ready) out_valid_r <= 1'b0;
      if (cfg_we && cfg_index == REG_SCALE) begin
        forced_r <= 1'b0;
        paused_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            out_r <= '0;
            unique case (in_ch.data.command)
              CMD_FRAME: begin
                last_stamp_r <= in_ch.data.timestamp_ns;
                cur_scale_r <= eff_scale;
                if (await_r) begin
                  await_r <= 1'b0;
                  out_r.first_frame <= 1'b1;
                  out_r.current_scale <= eff_scale;
                  out_r.is_paused <= (eff_scale == '0);
                  out_r.average_fps <= fps_r;
                  out_valid_r <= 1'b1;
                end else begin
                  raw_r <= raw_c;
                  capped_r <= (raw_c < max_frame_r) ? raw_c : max_frame_r;
                  state_r <= ST_MUL;
                end
              end
              CMD_PAUSE: begin
                paused_r <= 1'b1;
                out_r.current_scale <= '0;
                out_r.is_paused <= 1'b1;
                out_r.average_fps <= fps_r;
                out_valid_r <= 1'b1;
              end
              CMD_RESUME: begin
                paused_r <= 1'b0;
                out_r.current_scale <= forced_r ? UNIT_SCALE : scale_r;
                out_r.is_paused <= forced_r ? 1'b0 : (scale_r == '0);
                out_r.average_fps <= fps_r;
                out_valid_r <= 1'b1;
              end
              CMD_RESET: begin
                paused_r <= 1'b0;
                forced_r <= 1'b1;
                await_r <= 1'b1;
                leftover_r <= '0;
                last_stamp_r <= in_ch.data.timestamp_ns;
                win_ns_r <= '0;
                win_frames_r <= '0;
                fps_r <= '0;
                out_r.current_scale <= UNIT_SCALE;
                out_r.average_fps <= '0;
                out_valid_r <= 1'b1;
              end
              default: ;
            endcase
          end
        end
        ST_MUL: begin
          // Scaled time fits 40 bits, so no saturation is reachable.
          // The sum with the leftover can carry into bit 40.
          scaled_r <= prod[47:SCALE_FRAC_BITS];
          quo_r <= {23'd0, {1'b0, prod[47:SCALE_FRAC_BITS]} + {9'd0, leftover_r}};
          rem_r <= '0;
          dvsr_r <= {32'd0, step_eff};
          cnt_r <= 7'd63;
          state_r <= ST_DIVW;
        end
        ST_DIVW, ST_DIVA, ST_DIVF: begin
          if (!trial[64]) begin
            rem_r <= trial;
            quo_r <= {quo_r[62:0], 1'b1};
          end else begin
            rem_r <= {rem_r[63:0], quo_r[63]};
            quo_r <= {quo_r[62:0], 1'b0};
          end
          cnt_r <= cnt_r - 7'd1;
          if (cnt_r == '0) begin
            if (state_r == ST_DIVW) begin
              // Whole steps and leftover, then alpha = (leftover << 16) / step.
              leftover_r <= rem_fin[31:0];
              out_r.lagging <= (quo_fin > {56'd0, lim});
              out_r.physics_steps <= (quo_fin > {56'd0, lim}) ? lim : quo_fin[7:0];
              quo_r <= {16'd0, rem_fin[31:0], 16'd0};
              rem_r <= '0;
              cnt_r <= 7'd63;
              state_r <= ST_DIVA;
            end else if (state_r == ST_DIVA) begin
              out_r.interp_alpha <= quo_fin[15:0];
              out_r.raw_frame_ns <= raw_r;
              out_r.capped_frame_ns <= capped_r;
              out_r.scaled_frame_ns <= scaled_r;
              out_r.current_scale <= cur_scale_r;
              out_r.is_paused <= (cur_scale_r == '0);
              win_ns_r <= win_sum;
              win_frames_r <= frames_inc;
              if (win_sum >= FPS_WINDOW_NS) begin
                if (frames_inc > 32'h0400_0000) begin
                  fps_r <= 24'hFF_FFFF;
                  out_r.average_fps <= 24'hFF_FFFF;
                  win_ns_r <= '0;
                  win_frames_r <= '0;
                  state_r <= ST_DONE;
                end else begin
                  quo_r <= {fps_prod, 8'd0};
                  rem_r <= '0;
                  dvsr_r <= {31'd0, win_sum};
                  cnt_r <= 7'd63;
                  state_r <= ST_DIVF;
                end
              end else begin
                out_r.average_fps <= fps_r;
                state_r <= ST_DONE;
              end
            end else begin
              fps_r <= (quo_fin[63:24] != '0) ? 24'hFF_FFFF : quo_fin[23:0];
              out_r.average_fps <= (quo_fin[63:24] != '0) ? 24'hFF_FFFF : quo_fin[23:0];
              win_ns_r <= '0;
              win_frames_r <= '0;
              state_r <= ST_DONE;
            end
          end
        end
        ST_DONE: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r <= 1'b1;
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // The block never starts a transaction while busy.
  assert property (@(posedge clk) disable iff (!rst_n) (state_r != ST_IDLE) |-> !in_ch.ready)
    else $error("input ready while busy");
  // A pause always reports zero scale.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_ch.data.command == CMD_PAUSE) |=> (out_valid_r && out_r.is_paused))
    else $error("pause did not report paused");
  // The leftover stays below the step period after a frame.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE) |-> (leftover_r < step_eff))
    else $error("leftover not reduced");
  // A result never stalls the sequencer into losing it.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |=> out_valid_r)
    else $error("result dropped");
endmodule
`default_nettype wire

@@ tb/tb_fixed_timestep_accumulator.sv @@
// Self-checking testbench for the fixed timestep accumulator, with its own predictor.
module tb_fixed_timestep_accumulator;
  import fta_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  fta_in_if  in_ch ();
  fta_out_if out_ch ();

  fixed_timestep_accumulator dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_ch(in_ch), .out_ch(out_ch)
  );

  // Register copies and accumulator state as the predictor sees them.
  logic [31:0] step_reg, max_frame_reg;
  logic [7:0]  max_steps_reg;
  logic [15:0] scale_reg;
  logic [63:0] last_stamp;
  logic        awaiting_first;
  logic [31:0] leftover_ns;
  logic [32:0] window_ns;
  logic [31:0] window_frames;
  logic [23:0] fps_q8;
  logic        paused;
  logic        unit_forced;

  in_item_t  pending_cmds[$];
  out_item_t expected_results[$];
  logic [63:0] stamp_now;
  int        failures;
  int        gap_left, burst_left, stall_left, calm_left;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #50000000;
    $display("simulation failed");
    $finish;
  end

  function automatic logic [15:0] effective_scale();
    if (paused) return 16'd0;
    if (unit_forced) return UNIT_SCALE;
    return scale_reg;
  endfunction

  // Work out the result of one command and advance the predicted state.
  function automatic out_item_t predict_result(in_item_t it);
    out_item_t   r;
    logic [63:0] raw, step, lim, capped, scaled, acc, whole, alpha;
    logic [127:0] q;
    r = '0;
    if (it.command == CMD_FRAME) begin
      r.current_scale = effective_scale();
      if (awaiting_first) begin
        awaiting_first = 1'b0;
        last_stamp = it.timestamp_ns;
        r.first_frame = 1'b1;
      end else begin
        step = (step_reg == 0) ? 64'd1 : {32'd0, step_reg};
        lim = (max_steps_reg == 0) ? 64'd1 : {56'd0, max_steps_reg};
        raw = (it.timestamp_ns > last_stamp) ? it.timestamp_ns - last_stamp : 64'd0;
        if (raw > 64'hFFFF_FFFF) raw = 64'hFFFF_FFFF;
        capped = (raw < {32'd0, max_frame_reg}) ? raw : {32'd0, max_frame_reg};
        scaled = (capped * r.current_scale) >> SCALE_FRAC_BITS;
        if (scaled > 64'hFF_FFFF_FFFF) scaled = 64'hFF_FFFF_FFFF;
        last_stamp = it.timestamp_ns;
        acc = leftover_ns + scaled;
        whole = acc / step;
        r.lagging = (whole > lim);
        r.physics_steps = r.lagging ? lim[7:0] : whole[7:0];
        leftover_ns = acc % step;
        alpha = ({32'd0, leftover_ns} << 16) / step;
        r.interp_alpha = alpha[15:0];
        r.scaled_frame_ns = scaled[39:0];
        r.raw_frame_ns = raw[31:0];
        r.capped_frame_ns = capped[31:0];
        // Frame-rate window fed with the raw interval.
        window_ns = window_ns + raw[32:0];
        if (window_frames != 32'hFFFF_FFFF) window_frames++;
        if (window_ns >= FPS_WINDOW_NS) begin
          if (window_frames > 32'd67108864) begin
            fps_q8 = 24'hFF_FFFF;
          end else begin
            q = (128'(window_frames) * 128'(NS_PER_SEC_Q8)) / 128'(window_ns);
            fps_q8 = (q > 128'hFF_FFFF) ? 24'hFF_FFFF : q[23:0];
          end
          window_ns = '0;
          window_frames = '0;
        end
      end
    end else begin
      if (it.command == CMD_PAUSE) begin
        paused = 1'b1;
      end else if (it.command == CMD_RESUME) begin
        paused = 1'b0;
      end else begin
        awaiting_first = 1'b1;
        leftover_ns = '0;
        last_stamp = it.timestamp_ns;
        window_ns = '0;
        window_frames = '0;
        fps_q8 = '0;
        unit_forced = 1'b1;
        paused = 1'b0;
      end
      r.current_scale = effective_scale();
    end
    r.average_fps = fps_q8;
    r.is_paused = (r.current_scale == 0);
    return r;
  endfunction

  // Draw a command: mostly frames on a running clock, with pauses, resumes and resets.
  function automatic in_item_t random_command();
    in_item_t it;
    int sel;
    sel = $urandom_range(0, 99);
    it.command = CMD_FRAME;
    if (sel < 5) begin
      it.command = CMD_PAUSE;
      it.timestamp_ns = {$urandom, $urandom};
    end else if (sel < 10) begin
      it.command = CMD_RESUME;
      it.timestamp_ns = {$urandom, $urandom};
    end else if (sel < 13) begin
      it.command = CMD_RESET;
      stamp_now = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom} : stamp_now;
      it.timestamp_ns = stamp_now;
    end else begin
      sel = $urandom_range(0, 99);
      if (sel < 60) stamp_now = stamp_now + $urandom_range(0, 40000000);
      else if (sel < 75) stamp_now = stamp_now + $urandom_range(0, 32'h8000_0000);
      else if (sel < 83) stamp_now = {$urandom, $urandom};
      else if (sel < 92) stamp_now = stamp_now - $urandom_range(0, 1000000);
      else stamp_now = stamp_now + {28'd0, 4'($urandom), 32'($urandom)};
      it.timestamp_ns = stamp_now;
    end
    return it;
  endfunction

  function automatic void check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
      failures++;
    end
  endfunction

  // Driver: bursts of transactions separated by random gaps; valid holds until taken.
  always @(posedge clk) begin
    logic     next_valid;
    in_item_t next_data;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.data <= '0;
    end else begin
      next_valid = in_ch.valid;
      next_data = in_ch.data;
      if (in_ch.valid && in_ch.ready) begin
        expected_results.push_back(predict_result(in_ch.data));
        void'(pending_cmds.pop_front());
        next_valid = 1'b0;
      end
      if (!next_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_cmds.size() > 0) begin
          next_valid = 1'b1;
          next_data = pending_cmds[0];
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 30);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 300);
          end
        end
      end
      in_ch.valid <= next_valid;
      in_ch.data <= next_data;
    end
  end

  // Monitor: stalls come in runs, with calm stretches in between.
  always @(posedge clk) begin
    out_item_t e;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          $error("result transaction with no expectation waiting");
          failures++;
        end else begin
          e = expected_results.pop_front();
          check_field("physics_steps", e.physics_steps, out_ch.data.physics_steps);
          check_field("lagging", e.lagging, out_ch.data.lagging);
          check_field("interp_alpha", e.interp_alpha, out_ch.data.interp_alpha);
          check_field("scaled_frame_ns", e.scaled_frame_ns, out_ch.data.scaled_frame_ns);
          check_field("raw_frame_ns", e.raw_frame_ns, out_ch.data.raw_frame_ns);
          check_field("capped_frame_ns", e.capped_frame_ns, out_ch.data.capped_frame_ns);
          check_field("current_scale", e.current_scale, out_ch.data.current_scale);
          check_field("average_fps", e.average_fps, out_ch.data.average_fps);
          check_field("is_paused", e.is_paused, out_ch.data.is_paused);
          check_field("first_frame", e.first_frame, out_ch.data.first_frame);
        end
      end
      if (calm_left > 0) begin
        calm_left--;
        out_ch.ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        case ($urandom_range(0, 15))
          0: calm_left = $urandom_range(50, 2000);
          1, 2: stall_left = $urandom_range(1, 400);
          default: ;
        endcase
      end
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    case (idx)
      REG_STEP:      step_reg = value;
      REG_MAX_FRAME: max_frame_reg = value;
      REG_MAX_STEPS: max_steps_reg = value[7:0];
      default: begin
        scale_reg = value[15:0];
        unit_forced = 1'b0;
        paused = 1'b0;
      end
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic add_cmd(logic [1:0] command, logic [63:0] ts);
    in_item_t it;
    it.command = command;
    it.timestamp_ns = ts;
    pending_cmds.push_back(it);
  endtask

  // Wait for every transaction to drain, then wait on an idle stretch before returning.
  task automatic drain();
    while (pending_cmds.size() != 0 || in_ch.valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  initial begin
    logic [31:0] settings [6][4];
    settings = '{
      '{32'd16666667, 32'd250000000, 32'd5, 32'd256},
      '{32'd16666667, 32'd250000000, 32'd5, 32'd256},
      '{32'd1, 32'hFFFF_FFFF, 32'd255, 32'hFFFF},
      '{32'hFFFF_FFFF, 32'd1, 32'd1, 32'd0},
      '{32'd0, 32'd0, 32'd0, 32'd128},
      '{32'd1000000, 32'd50000000, 32'd8, 32'd512}
    };
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_STEP;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    failures = 0;
    gap_left = 0;
    burst_left = 0;
    stall_left = 0;
    calm_left = 0;
    stamp_now = 64'd5000;
    step_reg = 32'd16666667;
    max_frame_reg = 32'd250000000;
    max_steps_reg = 8'd5;
    scale_reg = UNIT_SCALE;
    last_stamp = '0;
    awaiting_first = 1'b1;
    leftover_ns = '0;
    window_ns = '0;
    window_frames = '0;
    fps_q8 = '0;
    paused = 1'b0;
    unit_forced = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed opening: first frame, backwards time, saturation, pause and reset cases.
    add_cmd(CMD_FRAME, 64'd1000);
    add_cmd(CMD_FRAME, 64'd16667667);
    add_cmd(CMD_FRAME, 64'd500);
    add_cmd(CMD_FRAME, 64'd500 + 64'h100_0000_0000);
    add_cmd(CMD_PAUSE, 64'd0);
    add_cmd(CMD_PAUSE, 64'd0);
    add_cmd(CMD_FRAME, 64'h100_0100_0000);
    add_cmd(CMD_RESUME, 64'hFFFF_FFFF_FFFF_FFFF);
    add_cmd(CMD_FRAME, 64'hFFFF_FFFF_FFFF_FFFF);
    add_cmd(CMD_RESET, 64'd0);
    add_cmd(CMD_FRAME, 64'd0);
    add_cmd(CMD_FRAME, 64'd500000000);
    add_cmd(CMD_FRAME, 64'd520000000);
    add_cmd(CMD_RESUME, 64'd0);
    add_cmd(CMD_RESET, 64'hFFFF_FFFF_FFFF_FFFF);
    add_cmd(CMD_FRAME, 64'hFFFF_FFFF_FFFF_FFFF);
    add_cmd(CMD_FRAME, 64'd0);
    add_cmd(CMD_PAUSE, 64'hAAAA_5555_AAAA_5555);
    add_cmd(CMD_RESET, 64'd7);
    drain();

    // Random phases under the register settings of the table; the first keeps the reset values.
    for (int p = 0; p < 6; p++) begin
      if (p > 0) begin
        for (int r = 0; r < 4; r++) write_reg(r[1:0], settings[p][r]);
      end
      for (int n = 0; n < 300; n++) pending_cmds.push_back(random_command());
      drain();
    end

    if (failures == 0 && expected_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
